@@ sv/idcv_pkg.sv @@
// Shared types, character constants and digit arithmetic for the ID number
// check digit validator. No dependencies.
package idcv_pkg;

   localparam int COUNT_W = 5;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_9       = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef struct packed {
      logic       number_valid;
      logic       length_ok;
      logic       chars_ok;
      logic       first_ok;
      logic       second_ok;
      logic [3:0] first_expected;
      logic [3:0] second_expected;
   } idcv_result_type;

   // Weight one digit (1 or 2), fold the product's digits, add mod 10.
   function automatic logic [3:0] add_digit(input logic [3:0] sum, input logic phase,
                                             input logic [3:0] d);
      logic [4:0] prod;
      logic [4:0] acc;
      prod = phase ? {d, 1'b0} : {1'b0, d};
      if (prod >= 5'd10) begin
         prod = prod - 5'd9;
      end
      acc = {1'b0, sum} + prod;
      if (acc >= 5'd10) begin
         acc = acc - 5'd10;
      end
      return acc[3:0];
   endfunction

   // Tens digit of a letter value 1..26.
   function automatic logic [3:0] letter_tens(input logic [4:0] v);
      logic [3:0] t;
      if (v >= 5'd20) begin
         t = 4'd2;
      end else if (v >= 5'd10) begin
         t = 4'd1;
      end else begin
         t = 4'd0;
      end
      return t;
   endfunction

   // Ones digit of a letter value 1..26.
   function automatic logic [3:0] letter_ones(input logic [4:0] v);
      logic [4:0] r;
      if (v >= 5'd20) begin
         r = v - 5'd20;
      end else if (v >= 5'd10) begin
         r = v - 5'd10;
      end else begin
         r = v;
      end
      return r[3:0];
   endfunction

endpackage

@@ sv/idcv_digit_acc.sv @@
// Running check-digit state: per-character decode, weighted digit sum and
// check captures. Depends on idcv_pkg.
module idcv_digit_acc import idcv_pkg::*; #(
   parameter int NUMBER_LENGTH   = 20,
   parameter int FIRST_CHECK_POS = 9
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      char_code,
   input  logic            is_last,
   output idcv_result_type result
);

   localparam logic [COUNT_W-1:0] LastPos  = COUNT_W'(NUMBER_LENGTH - 1);
   localparam logic [COUNT_W-1:0] FirstPos = COUNT_W'(FIRST_CHECK_POS);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               phase_ff, phase_in;
   logic [3:0]         sum_ff, sum_in;
   logic [3:0]         first_exp_ff, first_exp_in;
   logic               first_match_ff, first_match_in;
   logic [3:0]         second_exp_ff, second_exp_in;
   logic               second_match_ff, second_match_in;
   logic               bad_ff, bad_in;

   logic [7:0] code_up;
   logic       raw_digit;
   logic       is_digit;
   logic       is_letter;
   logic [4:0] letter_val;
   logic [3:0] code_digit;
   logic [3:0] sum_mid;
   logic       len_ok;

   always_comb begin
      raw_digit  = (char_code >= CHAR_0) && (char_code <= CHAR_9);
      code_digit = 4'(char_code - CHAR_0);
      code_up    = ((char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_Z))
                   ? char_code - CASE_OFFSET : char_code;
      is_digit   = (code_up >= CHAR_0) && (code_up <= CHAR_9);
      is_letter  = (code_up >= CHAR_UPPER_A) && (code_up <= CHAR_UPPER_Z);
      letter_val = 5'(code_up - CHAR_UPPER_A + 8'd1);
      sum_mid    = add_digit(sum_ff, phase_ff, letter_tens(letter_val));

      first_exp_in    = first_exp_ff;
      first_match_in  = first_match_ff;
      second_exp_in   = second_exp_ff;
      second_match_in = second_match_ff;
      if (count_ff == FirstPos) begin
         first_exp_in   = sum_ff;
         first_match_in = raw_digit && (code_digit == sum_ff);
      end
      if (count_ff == LastPos) begin
         second_exp_in   = sum_ff;
         second_match_in = raw_digit && (code_digit == sum_ff);
      end

      bad_in = bad_ff;
      if (is_digit) begin
         sum_in   = add_digit(sum_ff, phase_ff, 4'(code_up - CHAR_0));
         phase_in = ~phase_ff;
      end else if (is_letter) begin
         // two digits: phase flips twice
         sum_in   = add_digit(sum_mid, ~phase_ff, letter_ones(letter_val));
         phase_in = phase_ff;
      end else begin
         bad_in   = 1'b1;
         sum_in   = sum_ff;
         phase_in = ~phase_ff;
      end

      count_in = (count_ff < COUNT_MAX) ? count_ff + 1'b1 : count_ff;

      len_ok                 = (count_ff == LastPos);
      result.length_ok       = len_ok;
      result.chars_ok        = ~bad_in;
      result.first_ok        = len_ok && first_match_in;
      result.second_ok       = len_ok && second_match_in;
      result.number_valid    = len_ok && ~bad_in && first_match_in && second_match_in;
      result.first_expected  = first_exp_in;
      result.second_expected = second_exp_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && is_last)) begin
         count_ff        <= '0;
         phase_ff        <= 1'b0;
         sum_ff          <= '0;
         first_exp_ff    <= '0;
         first_match_ff  <= 1'b0;
         second_exp_ff   <= '0;
         second_match_ff <= 1'b0;
         bad_ff          <= 1'b0;
      end else if (step) begin
         count_ff        <= count_in;
         phase_ff        <= phase_in;
         sum_ff          <= sum_in;
         first_exp_ff    <= first_exp_in;
         first_match_ff  <= first_match_in;
         second_exp_ff   <= second_exp_in;
         second_match_ff <= second_match_in;
         bad_ff          <= bad_in;
      end
   end

endmodule

@@ sv/id_number_check_digit_validator.sv @@
// ID number check digit validator.
// Input channel req_*: one ASCII character per word, req_is_last marks the
// final character of a number. Letters of either case count as two decimal
// digits (A=01 .. Z=26); the digit stream is weighted 1,2,1,2 and the digit
// sums are kept mod 10. The check digit at FIRST_CHECK_POS and the last one
// (position NUMBER_LENGTH-1) are compared with the running sum.
// Result channel rsp_*: one word per number, sent for the marked last
// character, carrying the validity flags and both computed check digits.
// Throughput: one character per cycle while req_stall is low; the
// per-character sum update is combinational on the registered running state.
// Timing: an accepted word is held in the input register and decoded from
// there; the result for a last character is captured in the result register.
// rsp_stall holds the result word; the input register keeps taking
// characters that are not last, and stalls req_ only on a last character
// that finds the result register still occupied.
// Reset (synchronous, active high) empties both registers and clears the
// running sum, so the next character starts a new number.
// Depends on idcv_pkg and idcv_digit_acc.
module id_number_check_digit_validator import idcv_pkg::*; #(
   parameter int NUMBER_LENGTH   = 20,
   parameter int FIRST_CHECK_POS = 9
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_number_valid,
   output logic       rsp_length_ok,
   output logic       rsp_chars_ok,
   output logic       rsp_first_ok,
   output logic       rsp_second_ok,
   output logic [3:0] rsp_first_expected,
   output logic [3:0] rsp_second_expected
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_code_ff;
   logic            in_last_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   idcv_result_type rsp_ff;
   idcv_result_type result;
   logic            out_free;
   logic            step;
   logic            req_take;

   idcv_digit_acc #(
      .NUMBER_LENGTH  (NUMBER_LENGTH),
      .FIRST_CHECK_POS(FIRST_CHECK_POS)
   ) u_acc (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .char_code(in_code_ff),
      .is_last  (in_last_ff),
      .result   (result)
   );

   always_comb begin
      out_free     = ~rsp_valid_ff | ~rsp_stall;
      step         = in_valid_ff & (~in_last_ff | out_free);
      req_stall    = in_valid_ff & ~step;
      req_take     = req_valid & ~req_stall;
      in_valid_in  = req_take | (in_valid_ff & ~step);
      rsp_valid_in = (step & in_last_ff) | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_code_ff <= req_char_code;
         in_last_ff <= req_is_last;
      end
      if (step && in_last_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_number_valid    = rsp_ff.number_valid;
   assign rsp_length_ok       = rsp_ff.length_ok;
   assign rsp_chars_ok        = rsp_ff.chars_ok;
   assign rsp_first_ok        = rsp_ff.first_ok;
   assign rsp_second_ok       = rsp_ff.second_ok;
   assign rsp_first_expected  = rsp_ff.first_expected;
   assign rsp_second_expected = rsp_ff.second_expected;

`ifndef NO_ASSERTIONS
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && req_stall) |=> (in_valid_ff && $stable(in_code_ff)
                                      && $stable(in_last_ff)))
      else $error("input word lost while stalled");

   a_expected_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_first_expected <= 4'd9 && rsp_second_expected <= 4'd9))
      else $error("check digit out of range");

   a_flags_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!rsp_first_ok || rsp_length_ok) && (!rsp_second_ok || rsp_length_ok)
                     && (rsp_number_valid == (rsp_length_ok && rsp_chars_ok
                                              && rsp_first_ok && rsp_second_ok))))
      else $error("inconsistent result flags");
`endif

endmodule
